// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define LNP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lnp check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define LNP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lnp check failed");

`endif

// ===== hdl/lnp_pkg.sv =====
package lnp_pkg;

	localparam int VAL_W  = 4;
	localparam int CFG_W  = 4;
	localparam int WORD_W = 32;
	localparam int STAT_W = 2;
	localparam int WORD_POS = WORD_W / VAL_W;

	localparam logic [STAT_W-1:0] ST_IDENTITY = 2'd0;
	localparam logic [STAT_W-1:0] ST_ADVANCED = 2'd1;
	localparam logic [STAT_W-1:0] ST_LAST     = 2'd2;

	typedef struct packed {
		logic start;
		logic restart;
		logic out_free;
	} lnp_cmd_t;

	typedef struct packed {
		logic              idle;
		logic              done;
		logic [STAT_W-1:0] status;
	} lnp_rsp_t;

endpackage

// ===== hdl/lnp_if.sv =====
interface lnp_in_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

interface lnp_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] perm_word;
	logic [1:0]  status_code;

	modport source (output valid, output perm_word, output status_code, input ready);
	modport sink (input valid, input perm_word, input status_code, output ready);
endinterface

// ===== hdl/lnp_engine.sv =====
module lnp_engine #(
	parameter int MAX_LEN = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lnp_pkg::lnp_cmd_t          cmd,
	input  logic [lnp_pkg::CFG_W-1:0]  perm_length,
	output lnp_pkg::lnp_rsp_t          rsp,
	output logic [lnp_pkg::WORD_W-1:0] perm_word
);
	import lnp_pkg::*;

	localparam int IDX_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int LEN_W  = $clog2(MAX_LEN + 1);
	localparam int PACK_N = (MAX_LEN < WORD_POS) ? MAX_LEN : WORD_POS;
	localparam logic [4:0] MAX_LEN5 = 5'(MAX_LEN);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_LOAD   = 4'd1;
	localparam logic [3:0] S_SCAN_I = 4'd2;
	localparam logic [3:0] S_SCAN_J = 4'd3;
	localparam logic [3:0] S_SWAP_A = 4'd4;
	localparam logic [3:0] S_SWAP_B = 4'd5;
	localparam logic [3:0] S_REV_A  = 4'd6;
	localparam logic [3:0] S_REV_B  = 4'd7;
	localparam logic [3:0] S_REV_C  = 4'd8;
	localparam logic [3:0] S_DONE   = 4'd9;

	logic [3:0]        state_q;
	logic [VAL_W-1:0]  perm_q [MAX_LEN];
	logic [LEN_W-1:0]  active_len_q;
	logic [IDX_W-1:0]  p_q;
	logic [IDX_W-1:0]  j_q;
	logic [IDX_W-1:0]  lo_q;
	logic [VAL_W-1:0]  ref_q;
	logic [VAL_W-1:0]  t_q;
	logic [STAT_W-1:0] status_q;

	logic [IDX_W-1:0] rd_addr;
	logic [VAL_W-1:0] rd_data;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [VAL_W-1:0] wr_data;
	logic             load_id;
	logic             gt;
	logic [IDX_W-1:0] last_idx;
	logic [4:0]       len_clamp;

	assign last_idx = IDX_W'(active_len_q - LEN_W'(1));

	always_comb begin
		if (perm_length == '0) begin
			len_clamp = 5'd1;
		end else if ({1'b0, perm_length} > MAX_LEN5) begin
			len_clamp = MAX_LEN5;
		end else begin
			len_clamp = {1'b0, perm_length};
		end
	end

	// Single read port into the arrangement and one shared magnitude comparator.
	assign rd_data = perm_q[rd_addr];
	assign gt      = rd_data > ref_q;

	always_comb begin
		rd_addr = p_q;
		wr_en   = 1'b0;
		wr_addr = p_q;
		wr_data = t_q;
		load_id = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				load_id = cmd.start && cmd.restart;
			end
			S_LOAD: begin
				rd_addr = last_idx;
			end
			S_SCAN_I: begin
				rd_addr = p_q;
			end
			S_SCAN_J: begin
				rd_addr = j_q;
			end
			S_SWAP_A: begin
				wr_en   = 1'b1;
				wr_addr = p_q;
				wr_data = t_q;
			end
			S_SWAP_B: begin
				wr_en   = 1'b1;
				wr_addr = j_q;
				wr_data = ref_q;
			end
			S_REV_A: begin
				rd_addr = lo_q;
			end
			S_REV_B: begin
				rd_addr = j_q;
				wr_en   = 1'b1;
				wr_addr = lo_q;
				wr_data = rd_data;
			end
			S_REV_C: begin
				wr_en   = 1'b1;
				wr_addr = j_q;
				wr_data = t_q;
			end
			S_DONE: begin
				rd_addr = p_q;
			end
			default: begin
				rd_addr = p_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_LEN; k++) begin
				perm_q[k] <= VAL_W'(k + 1);
			end
		end else if (load_id) begin
			for (int k = 0; k < MAX_LEN; k++) begin
				perm_q[k] <= VAL_W'(k + 1);
			end
		end else if (wr_en) begin
			perm_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			active_len_q <= (MAX_LEN < 8) ? LEN_W'(MAX_LEN) : LEN_W'(8);
			status_q     <= ST_IDENTITY;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.start) begin
						if (cmd.restart) begin
							active_len_q <= LEN_W'(len_clamp);
							status_q     <= ST_IDENTITY;
							state_q      <= S_DONE;
						end else if (active_len_q <= LEN_W'(1)) begin
							status_q <= ST_LAST;
							state_q  <= S_DONE;
						end else begin
							state_q <= S_LOAD;
						end
					end
				end
				S_LOAD: begin
					state_q <= S_SCAN_I;
				end
				S_SCAN_I: begin
					if (!gt) begin
						state_q <= S_SCAN_J;
					end else if (p_q == '0) begin
						status_q <= ST_LAST;
						state_q  <= S_DONE;
					end
				end
				S_SCAN_J: begin
					if (gt || (j_q == IDX_W'(p_q + 1'b1))) begin
						state_q <= S_SWAP_A;
					end
				end
				S_SWAP_A: begin
					state_q <= S_SWAP_B;
				end
				S_SWAP_B: begin
					state_q <= S_REV_A;
				end
				S_REV_A: begin
					if (lo_q < j_q) begin
						state_q <= S_REV_B;
					end else begin
						status_q <= ST_ADVANCED;
						state_q  <= S_DONE;
					end
				end
				S_REV_B: begin
					state_q <= S_REV_C;
				end
				S_REV_C: begin
					state_q <= S_REV_A;
				end
				S_DONE: begin
					if (cmd.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers of the sequencer; they need no reset.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_LOAD: begin
				ref_q <= rd_data;
				p_q   <= IDX_W'(last_idx - 1'b1);
			end
			S_SCAN_I: begin
				// The pivot value stays in ref_q for the successor search and the swap.
				ref_q <= rd_data;
				if (gt) begin
					p_q <= IDX_W'(p_q - 1'b1);
				end else begin
					j_q <= last_idx;
				end
			end
			S_SCAN_J: begin
				if (gt || (j_q == IDX_W'(p_q + 1'b1))) begin
					t_q <= rd_data;
				end else begin
					j_q <= IDX_W'(j_q - 1'b1);
				end
			end
			S_SWAP_B: begin
				lo_q <= IDX_W'(p_q + 1'b1);
				j_q  <= last_idx;
			end
			S_REV_A: begin
				t_q <= rd_data;
			end
			S_REV_C: begin
				lo_q <= IDX_W'(lo_q + 1'b1);
				j_q  <= IDX_W'(j_q - 1'b1);
			end
			default: begin
				t_q <= t_q;
			end
		endcase
	end

	always_comb begin
		perm_word = '0;
		for (int k = 0; k < PACK_N; k++) begin
			if (LEN_W'(k) < active_len_q) begin
				perm_word[VAL_W*k +: VAL_W] = perm_q[k];
			end
		end
	end

	assign rsp.idle   = (state_q == S_IDLE);
	assign rsp.done   = (state_q == S_DONE) && cmd.out_free;
	assign rsp.status = status_q;

endmodule

// ===== hdl/lexicographic_next_permutation_core.sv =====
// Channel   Direction  Handshake      Payload
// req       in         valid/ready    restart
// rsp       out        valid/ready    perm_word, status_code
// cfg       in         cfg_we         cfg_wdata (perm_length)
//
// A restart loads the identity arrangement, and an advance of one element reports the last
// arrangement. Otherwise the sequencer scans for the pivot, which ends an exhausted walk,
// then for its successor, swaps the two and reverses the suffix pair by pair, all through
// the single read port and comparator. req.ready is high only while the sequencer is idle.
// A finished result waits in the sequencer until the output register is free.
// arst_n loads the identity arrangement and a length of 8, capped at MAX_LEN.
module lexicographic_next_permutation_core #(
	parameter int MAX_LEN = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	lnp_in_if.sink                    req,
	lnp_out_if.source                 rsp,
	input  logic                      cfg_we,
	input  logic [lnp_pkg::CFG_W-1:0] cfg_wdata
);
	import lnp_pkg::*;

	logic [CFG_W-1:0]  perm_length_q;
	lnp_cmd_t          cmd;
	lnp_rsp_t          eng_rsp;
	logic [WORD_W-1:0] eng_word;
	logic              out_valid_q;
	logic [WORD_W-1:0] out_word_q;
	logic [STAT_W-1:0] out_status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			perm_length_q <= CFG_W'(8);
		end else if (cfg_we) begin
			perm_length_q <= cfg_wdata;
		end
	end

	assign req.ready    = eng_rsp.idle;
	assign cmd.start    = req.valid && eng_rsp.idle;
	assign cmd.restart  = req.restart;
	assign cmd.out_free = !out_valid_q || rsp.ready;

	lnp_engine #(
		.MAX_LEN(MAX_LEN)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.perm_length(perm_length_q),
		.rsp        (eng_rsp),
		.perm_word  (eng_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (eng_rsp.done) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (eng_rsp.done) begin
			out_word_q   <= eng_word;
			out_status_q <= eng_rsp.status;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.perm_word   = out_word_q;
	assign rsp.status_code = out_status_q;

endmodule

// ===== hdl/lnp_checker.sv =====
module lnp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [31:0] perm_word,
	input logic [1:0]  status_code
);
	import lnp_pkg::*;

	`include "assert_macros.svh"

	// An accepted item occupies the sequencer, so the block cannot take another next cycle.
	`LNP_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)

	// A fresh identity arrangement always holds the value 1 at position zero.
	`LNP_ASSERT_NOW(a_identity_head, rsp_valid && (status_code == ST_IDENTITY), perm_word[3:0] == 4'd1)

	// A result is handed over only from the busy sequencer.
	`LNP_ASSERT_NOW(a_result_from_busy, $rose(rsp_valid), $past(!req_ready))

	`LNP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(perm_word) && $stable(status_code))

endmodule

bind lexicographic_next_permutation_core lnp_checker u_lnp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.perm_word  (rsp.perm_word),
	.status_code(rsp.status_code)
);
